FILE: hw/rtl/cfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_pkg: shared types and constants of the CRC-32 frame parser
// Phase codes, result kinds, the CRC-32 byte update and the parsed word.
// ----------------------------------------------------------------------------
package cfp_pkg;

   localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
   localparam logic [7:0]  SYNC_SECOND = 8'h5A;
   localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
   localparam logic [23:0] MAX_LENGTH_RESET = 24'd262144;

   typedef enum logic [2:0] {
      PH_SYNC0   = 3'd0,
      PH_SYNC1   = 3'd1,
      PH_TYPE    = 3'd2,
      PH_LEN     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CRC     = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      KIND_PAYLOAD_UNUSED = 3'd7
   } unused_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_BAD_CRC  = 2'd2,
      KIND_OVERSIZE = 2'd3
   } kind_type;

   // classified word handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  frame_type;
      logic [23:0] frame_length;
      logic [7:0]  data_byte;
      logic [23:0] byte_index;
   } event_type;

   // req channel word
   typedef struct packed {
      logic [7:0] rx_byte;
   } req_word_type;

   // rsp channel word
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  frame_type;
      logic [23:0] frame_length;
      logic [7:0]  data_byte;
      logic [23:0] byte_index;
      logic [31:0] good_count;
      logic [31:0] bad_crc_count;
      logic [31:0] oversize_count;
   } rsp_word_type;

   // reflected CRC-32 update over one byte (eight narrow dependent steps)
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = {24'd0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c ^ (crc >> 8);
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cfp_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_stream_if: valid/ready channel
// Carries one payload word of parameterized type between source and sink.
// ----------------------------------------------------------------------------
interface cfp_stream_if #(parameter type payload_type = logic [7:0]);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/crc32_frame_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_frame_parser_unit: sync/length/CRC-32 frame parser
// Top level joining front, queue and back.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one received byte per word (req_rx_byte).
//   rsp channel: zero or one result word per byte: payload byte, frame good,
//   frame bad CRC or oversize drop, with the three wrapping frame counters.
//   csr port: csr_write/csr_data set max_length; write only while idle.
// Throughput: one byte per cycle while the queue is not full. The front
// parses and updates the CRC in the accepting cycle; the per-byte CRC step
// sets the cycle time. A result's word is written into the queue at the edge
// that accepts its byte and enters the result register once that is free.
// Stall: a stalled rsp side fills the two-entry queue, after which req_ready
// drops; no word is lost.
// Reset: synchronous; hunts for sync, counters zero, max_length 262144.
// ----------------------------------------------------------------------------
module crc32_frame_parser_unit #(
   parameter int LENGTH_BITS = 24
) (
   input  wire logic   clock,
   input  wire logic   reset,
   cfp_stream_if.sink  req,
   cfp_stream_if.source rsp,
   input  wire logic        csr_write,
   input  wire logic [23:0] csr_data
);

   logic [23:0] max_len_ff;
   logic        push, full, pop_valid, pop;
   cfp_pkg::event_type push_word, pop_word, out_word;
   logic [31:0] good, bad, over;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) max_len_ff <= cfp_pkg::MAX_LENGTH_RESET;
      else if (csr_write) max_len_ff <= csr_data;
   end

   cfp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_byte(req.payload.rx_byte), .in_ready(req.ready),
      .max_length(max_len_ff), .push, .push_word, .full
   );

   cfp_queue u_queue (
      .clock, .reset, .push, .push_word, .full, .pop_valid, .pop_word, .pop
   );

   cfp_back u_back (
      .clock, .reset, .pop_valid, .pop_word, .pop,
      .out_valid(rsp.valid), .out_word, .out_good(good), .out_bad(bad),
      .out_over(over), .out_ready(rsp.ready)
   );

   // result fields
   assign rsp.payload.kind           = out_word.kind;
   assign rsp.payload.frame_type     = out_word.frame_type;
   assign rsp.payload.frame_length   = out_word.frame_length;
   assign rsp.payload.data_byte      = out_word.data_byte;
   assign rsp.payload.byte_index     = out_word.byte_index;
   assign rsp.payload.good_count     = good;
   assign rsp.payload.bad_crc_count  = bad;
   assign rsp.payload.oversize_count = over;

   // queue never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   // a held result stays put while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(good)) else $error("result lost");
   // a popped word is always taken into the result register
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp.valid) else $error("pop without result");

endmodule
`default_nettype wire

FILE: hw/rtl/cfp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_front: sync hunt, header decode and CRC tracking
// One byte a cycle unless full; at most one classified word pushed per byte.
// ----------------------------------------------------------------------------
module cfp_front #(
   parameter int LENGTH_BITS = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [7:0]           in_byte,
   output logic                      in_ready,
   input  wire logic [23:0]          max_length,
   output logic                      push,
   output cfp_pkg::event_type        push_word,
   input  wire logic                 full
);

   localparam logic [31:0] LEN_LIMIT = 32'((64'd1 << LENGTH_BITS) - 64'd1);

   cfp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [1:0]  field_ff, field_in;
   logic [31:0] len_ff, len_in;
   logic [23:0] pcount_ff, pcount_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] crcsh_ff, crcsh_in;
   logic        fire;
   logic [31:0] crc_upd;
   logic [31:0] len_shift, crc_shifted;
   logic [31:0] len_sat;
   logic        oversize;
   logic [23:0] pcount_next;

   assign in_ready = !full;
   assign fire     = in_valid && !full;

   // shared datapath terms
   assign crc_upd     = cfp_pkg::crc_byte((phase_ff == cfp_pkg::PH_TYPE) ?
                                          cfp_pkg::CRC_INIT : crc_ff, in_byte);
   assign len_shift   = {in_byte, len_ff[31:8]};
   assign crc_shifted = {in_byte, crcsh_ff[31:8]};
   assign oversize    = (len_shift > {8'd0, max_length}) || (len_shift > LEN_LIMIT);
   assign len_sat     = (len_shift > LEN_LIMIT) ? LEN_LIMIT : len_shift;
   assign pcount_next = 24'((32'(pcount_ff) + 32'd1) & LEN_LIMIT);

   // next state
   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      field_in  = field_ff;
      len_in    = len_ff;
      pcount_in = pcount_ff;
      crc_in    = crc_ff;
      crcsh_in  = crcsh_ff;
      unique case (phase_ff)
         cfp_pkg::PH_SYNC1: begin
            if (in_byte == cfp_pkg::SYNC_SECOND) phase_in = cfp_pkg::PH_TYPE;
            else if (in_byte != cfp_pkg::SYNC_FIRST) phase_in = cfp_pkg::PH_SYNC0;
         end
         cfp_pkg::PH_TYPE: begin
            type_in  = in_byte;
            field_in = 2'd0;
            crc_in   = crc_upd;
            phase_in = cfp_pkg::PH_LEN;
         end
         cfp_pkg::PH_LEN: begin
            len_in = len_shift;
            crc_in = crc_upd;
            if (field_ff != 2'd3) begin
               field_in = field_ff + 2'd1;
            end else if (oversize) begin
               phase_in = cfp_pkg::PH_SYNC0; type_in = '0; field_in = '0;
               len_in = '0; pcount_in = '0;
            end else begin
               pcount_in = '0; field_in = '0; crcsh_in = '0;
               phase_in = (len_shift == 32'd0) ? cfp_pkg::PH_CRC : cfp_pkg::PH_PAYLOAD;
            end
         end
         cfp_pkg::PH_PAYLOAD: begin
            crc_in    = crc_upd;
            pcount_in = pcount_next;
            if (32'(pcount_next) == len_ff) begin
               field_in = '0; crcsh_in = '0; phase_in = cfp_pkg::PH_CRC;
            end
         end
         cfp_pkg::PH_CRC: begin
            crcsh_in = crc_shifted;
            if (field_ff != 2'd3) begin
               field_in = field_ff + 2'd1;
            end else begin
               phase_in = cfp_pkg::PH_SYNC0; type_in = '0; field_in = '0;
               len_in = '0; pcount_in = '0;
            end
         end
         default: begin
            phase_in = (in_byte == cfp_pkg::SYNC_FIRST) ? cfp_pkg::PH_SYNC1
                                                         : cfp_pkg::PH_SYNC0;
         end
      endcase
   end

   // outputs
   always_comb begin
      push = 1'b0;
      push_word.kind         = cfp_pkg::KIND_PAYLOAD;
      push_word.frame_type   = type_ff;
      push_word.frame_length = len_ff[23:0];
      push_word.data_byte    = 8'd0;
      push_word.byte_index   = 24'd0;
      unique case (phase_ff)
         cfp_pkg::PH_LEN: begin
            if (field_ff == 2'd3 && oversize) begin
               push = fire;
               push_word.kind         = cfp_pkg::KIND_OVERSIZE;
               push_word.frame_length = len_sat[23:0];
            end
         end
         cfp_pkg::PH_PAYLOAD: begin
            push = fire;
            push_word.data_byte  = in_byte;
            push_word.byte_index = pcount_ff;
         end
         cfp_pkg::PH_CRC: begin
            if (field_ff == 2'd3) begin
               push = fire;
               push_word.kind = (crc_shifted == ~crc_ff) ? cfp_pkg::KIND_GOOD
                                                         : cfp_pkg::KIND_BAD_CRC;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= cfp_pkg::PH_SYNC0;
         type_ff   <= '0;
         field_ff  <= '0;
         len_ff    <= '0;
         pcount_ff <= '0;
         crc_ff    <= cfp_pkg::CRC_INIT;
         crcsh_ff  <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         field_ff  <= field_in;
         len_ff    <= len_in;
         pcount_ff <= pcount_in;
         crc_ff    <= crc_in;
         crcsh_ff  <= crcsh_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/cfp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_queue: two-entry word queue
// Decouples the front from the back; full only when both entries are held.
// ----------------------------------------------------------------------------
module cfp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  cfp_pkg::event_type      push_word,
   output logic                    full,
   output logic                    pop_valid,
   output cfp_pkg::event_type      pop_word,
   input  wire logic               pop
);

   cfp_pkg::event_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_word  = mem_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_word;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/cfp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_back: frame counters and result register
// Pops one word, bumps the matching counter and holds the result until taken.
// ----------------------------------------------------------------------------
module cfp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   input  cfp_pkg::event_type     pop_word,
   output logic                   pop,
   output logic                   out_valid,
   output cfp_pkg::event_type     out_word,
   output logic [31:0]            out_good,
   output logic [31:0]            out_bad,
   output logic [31:0]            out_over,
   input  wire logic              out_ready
);

   logic        valid_ff;
   logic [31:0] good_ff, bad_ff, over_ff;
   logic [31:0] good_in, bad_in, over_in;
   cfp_pkg::event_type word_ff;
   logic [31:0] rg_ff, rb_ff, ro_ff;

   assign pop       = pop_valid && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_good  = rg_ff;
   assign out_bad   = rb_ff;
   assign out_over  = ro_ff;

   // counter update by kind
   always_comb begin
      good_in = good_ff; bad_in = bad_ff; over_in = over_ff;
      case (pop_word.kind)
         cfp_pkg::KIND_GOOD:     good_in = good_ff + 32'd1;
         cfp_pkg::KIND_BAD_CRC:  bad_in  = bad_ff + 32'd1;
         cfp_pkg::KIND_OVERSIZE: over_in = over_ff + 32'd1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         good_ff <= '0; bad_ff <= '0; over_ff <= '0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            good_ff <= good_in; bad_ff <= bad_in; over_ff <= over_in;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         word_ff <= pop_word;
         rg_ff <= good_in; rb_ff <= bad_in; ro_ff <= over_in;
      end
   end

endmodule
`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: testbench of the CRC-32 frame parser unit
// Feeds directed and random byte streams (frames, noise, broken frames),
// predicts every result word and its counters, and compares field by field.
// ----------------------------------------------------------------------------

// frame parser prediction and result matching
class frame_scoreboard;
   logic [23:0] max_len;
   cfp_pkg::phase_type phase;
   logic [7:0]  type_q;
   logic [1:0]  field_q;
   logic [31:0] len_q;
   logic [23:0] pay_cnt;
   logic [31:0] crc_q;
   logic [31:0] crc_rx;
   logic [31:0] n_good, n_bad, n_over;
   cfp_pkg::rsp_word_type expected_q[$];
   int          errors;
   int          checked;

   function new();
      max_len = cfp_pkg::MAX_LENGTH_RESET;
      errors = 0;
      checked = 0;
      n_good = 0;
      n_bad = 0;
      n_over = 0;
      crc_q = '1;
      crc_rx = 0;
      restart();
   endfunction

   function void restart();
      phase = cfp_pkg::PH_SYNC0;
      type_q = 0;
      field_q = 0;
      len_q = 0;
      pay_cnt = 0;
   endfunction

   function void push(cfp_pkg::kind_type k, logic [23:0] len, logic [7:0] d,
                      logic [23:0] idx);
      cfp_pkg::rsp_word_type w;
      w.kind = k;
      w.frame_type = type_q;
      w.frame_length = len;
      w.data_byte = d;
      w.byte_index = idx;
      w.good_count = n_good;
      w.bad_crc_count = n_bad;
      w.oversize_count = n_over;
      expected_q.push_back(w);
   endfunction

   // one accepted input byte
   function void note_byte(logic [7:0] b);
      case (phase)
         cfp_pkg::PH_SYNC1: begin
            if (b == cfp_pkg::SYNC_SECOND) phase = cfp_pkg::PH_TYPE;
            else if (b != cfp_pkg::SYNC_FIRST) phase = cfp_pkg::PH_SYNC0;
         end
         cfp_pkg::PH_TYPE: begin
            type_q = b;
            field_q = 0;
            crc_q = cfp_pkg::crc_byte('1, b);
            phase = cfp_pkg::PH_LEN;
         end
         cfp_pkg::PH_LEN: begin
            len_q = {b, len_q[31:8]};
            crc_q = cfp_pkg::crc_byte(crc_q, b);
            if (field_q != 3) begin
               field_q++;
            end else if (len_q > {8'd0, max_len} || len_q > 32'hFFFFFF) begin
               n_over++;
               push(cfp_pkg::KIND_OVERSIZE,
                    (len_q > 32'hFFFFFF) ? 24'hFFFFFF : len_q[23:0], 8'd0, 24'd0);
               restart();
            end else begin
               pay_cnt = 0;
               field_q = 0;
               crc_rx = 0;
               phase = (len_q == 0) ? cfp_pkg::PH_CRC : cfp_pkg::PH_PAYLOAD;
            end
         end
         cfp_pkg::PH_PAYLOAD: begin
            crc_q = cfp_pkg::crc_byte(crc_q, b);
            push(cfp_pkg::KIND_PAYLOAD, len_q[23:0], b, pay_cnt);
            pay_cnt++;
            if ({8'd0, pay_cnt} == len_q) begin
               field_q = 0;
               crc_rx = 0;
               phase = cfp_pkg::PH_CRC;
            end
         end
         cfp_pkg::PH_CRC: begin
            crc_rx = {b, crc_rx[31:8]};
            if (field_q != 3) begin
               field_q++;
            end else begin
               if (crc_rx == ~crc_q) begin
                  n_good++;
                  push(cfp_pkg::KIND_GOOD, len_q[23:0], 8'd0, 24'd0);
               end else begin
                  n_bad++;
                  push(cfp_pkg::KIND_BAD_CRC, len_q[23:0], 8'd0, 24'd0);
               end
               restart();
            end
         end
         default: phase = (b == cfp_pkg::SYNC_FIRST) ? cfp_pkg::PH_SYNC1
                                                     : cfp_pkg::PH_SYNC0;
      endcase
   endfunction

   // one accepted result word
   function void check_word(cfp_pkg::rsp_word_type got);
      cfp_pkg::rsp_word_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result word %h", $time, got);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.kind !== e.kind)
         $display("%0t: kind exp %0d got %0d", $time, e.kind, got.kind);
      if (got.frame_type !== e.frame_type)
         $display("%0t: frame_type exp %h got %h", $time, e.frame_type, got.frame_type);
      if (got.frame_length !== e.frame_length)
         $display("%0t: frame_length exp %h got %h", $time, e.frame_length,
                  got.frame_length);
      if (got.data_byte !== e.data_byte)
         $display("%0t: data_byte exp %h got %h", $time, e.data_byte, got.data_byte);
      if (got.byte_index !== e.byte_index)
         $display("%0t: byte_index exp %0d got %0d", $time, e.byte_index, got.byte_index);
      if (got.good_count !== e.good_count)
         $display("%0t: good_count exp %0d got %0d", $time, e.good_count, got.good_count);
      if (got.bad_crc_count !== e.bad_crc_count)
         $display("%0t: bad_crc_count exp %0d got %0d", $time, e.bad_crc_count,
                  got.bad_crc_count);
      if (got.oversize_count !== e.oversize_count)
         $display("%0t: oversize_count exp %0d got %0d", $time, e.oversize_count,
                  got.oversize_count);
      if (got !== e) errors++;
   endfunction
endclass

module tb;
   localparam int QUIET_LIMIT = 5000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [23:0] csr_data = 0;
   int          send_idle_pct = 10;
   int          recv_idle_pct = 58;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int          bytes_sent = 0;
   frame_scoreboard board = new();

   cfp_stream_if #(.payload_type(cfp_pkg::req_word_type)) req_if ();
   cfp_stream_if #(.payload_type(cfp_pkg::rsp_word_type)) rsp_if ();

   crc32_frame_parser_unit uut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   initial begin
      req_if.valid = 0;
      req_if.payload = '0;
      rsp_if.ready = 0;
   end

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: note accepted bytes, check accepted results, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) board.note_byte(req_if.payload.rx_byte);
         if (rsp_if.valid && rsp_if.ready) board.check_word(rsp_if.payload);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > QUIET_LIMIT) begin
            $display("%0t: no progress, giving up", $time);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // one word on req, holding until accepted; valid stays high afterward
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.payload.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   // drop valid and let the last accept settle
   task automatic stop_req();
      req_if.valid <= 0;
      @(posedge clock);
   endtask

   // full frame; len32 is the on-wire length, bad_crc flips one CRC bit
   task automatic send_frame(input logic [7:0] ftype, input logic [31:0] len32,
                             input int pay_bytes, input bit bad_crc);
      logic [31:0] crc;
      logic [7:0]  d;
      crc = cfp_pkg::crc_byte('1, ftype);
      send_byte(cfp_pkg::SYNC_FIRST);
      send_byte(cfp_pkg::SYNC_SECOND);
      send_byte(ftype);
      for (int i = 0; i < 4; i++) begin
         crc = cfp_pkg::crc_byte(crc, len32[8*i +: 8]);
         send_byte(len32[8*i +: 8]);
      end
      for (int i = 0; i < pay_bytes; i++) begin
         d = 8'($urandom_range(255));
         crc = cfp_pkg::crc_byte(crc, d);
         send_byte(d);
      end
      crc = ~crc;
      if (bad_crc) crc ^= 32'h1 << $urandom_range(31);
      for (int i = 0; i < 4; i++) send_byte(crc[8*i +: 8]);
   endtask

   // register write once the block has drained
   task automatic set_max(input logic [23:0] v);
      stop_req();
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write <= 1;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 0;
      board.max_len = v;
   endtask

   // random mix: mostly well-formed frames, some noise and cut frames
   task automatic random_traffic(input int n_bytes);
      int start;
      int r;
      int len;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         r = $urandom_range(99);
         len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
         if (r < 60)
            send_frame(8'($urandom_range(255)), 32'(len), len, 1'b0);
         else if (r < 75)
            send_frame(8'($urandom_range(255)), 32'(len), len, 1'b1);
         else if (r < 83)
            send_frame(8'($urandom_range(255)), $urandom, 0, 1'b0);
         else if (r < 91) begin
            // cut frame: header then noise
            send_byte(cfp_pkg::SYNC_FIRST);
            send_byte(cfp_pkg::SYNC_SECOND);
            repeat ($urandom_range(6)) send_byte(8'($urandom_range(255)));
         end else
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: noise, repeated first sync byte, extremes
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(cfp_pkg::SYNC_FIRST);
      send_byte(cfp_pkg::SYNC_FIRST);
      send_byte(cfp_pkg::SYNC_SECOND);
      send_byte(8'hFF);
      repeat (4) send_byte(8'h00);        // zero length
      repeat (4) send_byte(8'hFF);        // CRC (bad)
      send_frame(8'h00, 0, 0, 1'b0);          // zero length, good
      send_frame(8'hFF, 3, 3, 1'b0);
      send_frame(8'h5A, 2, 2, 1'b1);
      send_frame(8'h12, 32'hFFFF_FFFF, 0, 1'b0); // above the field limit
      send_frame(8'h34, 32'h0004_0001, 0, 1'b0); // above reset maximum

      // sender idles lightly, receiver heavily, with a long hold-off
      hold_left <= 300;
      random_traffic(300);

      set_max(0);
      send_frame(8'h01, 0, 0, 1'b0);
      send_frame(8'h02, 1, 0, 1'b0);
      set_max(24'hFFFFFF);
      send_frame(8'h03, 32'h0100_0000, 0, 1'b0); // one above the field limit
      repeat (6) send_byte(8'h00);
      set_max(5);
      send_idle_pct = 58;
      recv_idle_pct = 10;
      random_traffic(300);

      set_max(cfp_pkg::MAX_LENGTH_RESET);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_traffic(300);

      // drain, then a quiet tail
      stop_req();
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d bytes, checked %0d result words (%0d good, %0d bad, %0d oversize).",
               bytes_sent, board.checked, board.n_good, board.n_bad, board.n_over);
      $display("Covered sync hunting, zero length, CRC errors, oversize and stalls.");
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: crc32_frame_parser_unit.f
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_stream_if.sv
hw/rtl/cfp_front.sv
hw/rtl/cfp_queue.sv
hw/rtl/cfp_back.sv
hw/rtl/crc32_frame_parser_unit.sv
verif/tb.sv
